// ----- design/ruit_pkg.sv -----
`default_nettype none
package ruit_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int KIND_W = 2;
    localparam int TV_W   = 64;
    localparam int ID_W   = 16;
    localparam int SLOT_W = 8;
    localparam int STAT_W = 2;
    localparam int SPAN_W = ID_W + 1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GEN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SLOT  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // splitmix64 finalizer
    localparam logic [TV_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [TV_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TV_W-1:0]   timer_value;
        logic [ID_W-1:0]   range_low;
        logic [ID_W-1:0]   range_high;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   add_value;
    } t_in_req;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] status;
    } t_out_rsp;

    // table command and response
    typedef struct packed {
        logic              clear;
        logic              wr;
        logic              rd;
        logic              scan;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   data;
    } t_tbl_cmd;

    typedef struct packed {
        logic            done;
        logic            hit;
        logic            occ;
        logic [ID_W-1:0] rdata;
    } t_tbl_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_MOD,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- design/random_unique_id_table.sv -----
// Random unique id table.
// Request channel: i_in_valid / o_in_stall carry one t_in_req. A request is
// taken when i_in_valid is high and o_in_stall low. o_in_stall is high from
// the cycle after a request is taken until its result sits in the output
// register; one request is worked on at a time.
// Result channel: o_out_valid / i_out_stall carry one t_out_rsp per request.
// The output register holds a result while i_out_stall is high; the next
// request may be taken meanwhile, but its result waits in the sequencer.
// Work per request, in order, before the result is handed to the output
// register:
//   clear    : two-round multiply sequence, then handoff
//   generate : mix, 64-step remainder, then a memory scan over all
//              TABLE_DEPTH entries, one read per cycle
//   add/read : one memory read
//   slot or range error: handoff only
// Reset (synchronous, active low) clears the seed, every occupied flag and
// all control state; entries without an occupied flag read as zero, so the
// id memory itself needs no clearing pass.
`default_nettype none
module random_unique_id_table #(
    parameter int TABLE_DEPTH = ruit_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ruit_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ruit_pkg::t_out_rsp     o_out_rsp
);
    import ruit_pkg::*;

    t_state          r_state, n_state;
    t_in_req         r_req;
    logic [TV_W-1:0] r_seed, n_seed;
    logic [ID_W-1:0] r_cand, n_cand;
    t_out_rsp        r_res, n_res;
    logic            r_out_vld;
    t_out_rsp        r_out;

    logic              w_accept;
    logic              w_load_out;
    logic              mix_start;
    logic [TV_W-1:0]   mix_value;
    logic              mix_done;
    logic [TV_W-1:0]   mix_result;
    logic              mod_start;
    logic [SPAN_W-1:0] mod_span;
    logic              mod_done;
    logic [SPAN_W-1:0] mod_rem;
    t_tbl_cmd          tbl_cmd;
    t_tbl_rsp          tbl_rsp;

    assign w_accept = i_in_valid && !o_in_stall;
    // span of the id range; 0..65535 gives 65536 in 17 bits
    assign mod_span = {1'b0, r_req.range_high} - {1'b0, r_req.range_low} + SPAN_W'(1);

    ruit_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_value  (mix_value),
        .o_done   (mix_done),
        .o_result (mix_result)
    );

    ruit_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mix_result),
        .i_divisor  (mod_span),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    ruit_tbl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_rsp   (tbl_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seed    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_req;
        end
        r_cand <= n_cand;
        r_res  <= n_res;
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_seed     = r_seed;
        n_cand     = r_cand;
        n_res      = r_res;
        mix_start  = 1'b0;
        mix_value  = i_in_req.timer_value;
        mod_start  = 1'b0;
        tbl_cmd    = '0;
        w_load_out = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    tbl_cmd.slot = i_in_req.slot;
                    if (i_in_req.kind == KIND_CLEAR) begin
                        tbl_cmd.clear = 1'b1;
                        mix_start     = 1'b1;
                        n_state       = S_MIX;
                    end else if (i_in_req.slot >= SLOT_W'(TABLE_DEPTH)) begin
                        n_res   = '{id: '0, status: STAT_SLOT};
                        n_state = S_DONE;
                    end else begin
                        case (i_in_req.kind)
                            KIND_GEN: begin
                                if (i_in_req.range_high < i_in_req.range_low) begin
                                    n_res   = '{id: '0, status: STAT_RANGE};
                                    n_state = S_DONE;
                                end else begin
                                    mix_value = r_seed ^ i_in_req.timer_value;
                                    mix_start = 1'b1;
                                    n_state   = S_MIX;
                                end
                            end
                            default: begin
                                tbl_cmd.rd = 1'b1;
                                n_state    = S_READ;
                            end
                        endcase
                    end
                end
            end
            S_MIX: begin
                if (mix_done) begin
                    n_seed = mix_result;
                    if (r_req.kind == KIND_CLEAR) begin
                        n_res   = '{id: '0, status: STAT_OK};
                        n_state = S_DONE;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    // lo + rem never passes range_high, so 16 bits hold it
                    n_cand       = r_req.range_low + mod_rem[ID_W-1:0];
                    tbl_cmd.scan = 1'b1;
                    tbl_cmd.data = n_cand;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tbl_rsp.done) begin
                    if (tbl_rsp.hit) begin
                        n_res = '{id: r_cand, status: STAT_BUSY};
                    end else begin
                        tbl_cmd.wr   = 1'b1;
                        tbl_cmd.slot = r_req.slot;
                        tbl_cmd.data = r_cand;
                        n_res        = '{id: r_cand, status: STAT_OK};
                    end
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (tbl_rsp.done) begin
                    if (r_req.kind == KIND_ADD) begin
                        if (tbl_rsp.occ) begin
                            n_res = '{id: '0, status: STAT_BUSY};
                        end else begin
                            tbl_cmd.wr   = 1'b1;
                            tbl_cmd.slot = r_req.slot;
                            tbl_cmd.data = r_req.add_value;
                            n_res        = '{id: '0, status: STAT_OK};
                        end
                    end else begin
                        n_res = '{id: tbl_rsp.rdata, status: STAT_OK};
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_vld || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

endmodule
`default_nettype wire

// ----- design/ruit_mix.sv -----
`default_nettype none
// splitmix64 finalizer on one shared 32x32 multiplier, 4 steps per 64-bit product
module ruit_mix (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [ruit_pkg::TV_W-1:0] i_value,
    output logic                         o_done,
    output logic [ruit_pkg::TV_W-1:0]    o_result
);
    import ruit_pkg::*;

    localparam int HW = TV_W / 2;

    logic            r_busy;
    logic            r_round;
    logic [1:0]      r_sub;
    logic            r_done;
    logic [TV_W-1:0] r_v;
    logic [TV_W-1:0] r_acc;
    logic [TV_W-1:0] r_prod;

    logic [TV_W-1:0] w_mul_k;
    logic [HW-1:0]   w_op_a;
    logic [HW-1:0]   w_op_b;
    logic [TV_W-1:0] w_prod;
    logic [TV_W-1:0] w_full;
    logic [TV_W-1:0] w_fin;

    always_comb begin
        w_mul_k = r_round ? MIX_MUL_B : MIX_MUL_A;
        case (r_sub)
            2'd0: begin
                w_op_a = r_v[HW-1:0];
                w_op_b = w_mul_k[HW-1:0];
            end
            2'd1: begin
                w_op_a = r_v[HW-1:0];
                w_op_b = w_mul_k[TV_W-1:HW];
            end
            default: begin
                w_op_a = r_v[TV_W-1:HW];
                w_op_b = w_mul_k[HW-1:0];
            end
        endcase
        w_prod = TV_W'(w_op_a) * TV_W'(w_op_b);
        w_full = {r_acc[TV_W-1:HW] + r_prod[HW-1:0], r_acc[HW-1:0]};
        w_fin  = r_round ? (w_full ^ (w_full >> MIX_SH2)) : (w_full ^ (w_full >> MIX_SH1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_sub   <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 1'b0;
                r_sub   <= 2'd0;
            end else if (r_busy) begin
                r_sub <= r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    r_round <= 1'b1;
                    if (r_round) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value ^ (i_value >> MIX_SH0);
        end else if (r_busy) begin
            r_prod <= w_prod;
            case (r_sub)
                2'd1: r_acc <= r_prod;
                2'd2: r_acc[TV_W-1:HW] <= r_acc[TV_W-1:HW] + r_prod[HW-1:0];
                2'd3: r_v <= w_fin;
                default: ;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_v;

endmodule
`default_nettype wire

// ----- design/ruit_mod.sv -----
`default_nettype none
// restoring remainder, one dividend bit per cycle
module ruit_mod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ruit_pkg::TV_W-1:0]   i_dividend,
    input  wire logic [ruit_pkg::SPAN_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [ruit_pkg::SPAN_W-1:0]    o_rem
);
    import ruit_pkg::*;

    localparam int CNT_W = $clog2(TV_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TV_W-1:0]   r_dvd;
    logic [SPAN_W-1:0] r_div;
    logic [SPAN_W-1:0] r_rem;

    logic [SPAN_W:0]   w_trial;
    logic [SPAN_W:0]   w_sub;
    logic [SPAN_W-1:0] w_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[TV_W-1]};
        w_sub   = w_trial - {1'b0, r_div};
        w_rem   = (w_trial >= {1'b0, r_div}) ? w_sub[SPAN_W-1:0] : w_trial[SPAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- design/ruit_tbl.sv -----
`default_nettype none
// id memory with occupied flags; one read per cycle, scan compares one entry per cycle
module ruit_tbl #(
    parameter int TABLE_DEPTH = ruit_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ruit_pkg::t_tbl_cmd i_cmd,
    output ruit_pkg::t_tbl_rsp     o_rsp
);
    import ruit_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [ID_W-1:0]        r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_occ;

    logic             r_scanning;
    logic [IDX_W-1:0] r_scan_idx;
    logic [ID_W-1:0]  r_cand;
    logic             r_hit;
    logic             r_rd_vld;
    logic             r_rd_scan;
    logic             r_rd_last;
    logic             r_rd_occ;
    logic [ID_W-1:0]  r_rdata;

    logic [IDX_W-1:0] w_slot;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_rd_en;
    logic             w_scan_last;
    logic             w_match;

    always_comb begin
        w_slot      = i_cmd.slot[IDX_W-1:0];
        w_rd_idx    = r_scanning ? r_scan_idx : w_slot;
        w_rd_en     = r_scanning || i_cmd.rd;
        w_scan_last = (r_scan_idx == IDX_W'(TABLE_DEPTH - 1));
        w_match     = r_rd_occ && (r_rdata == r_cand);
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[w_slot] <= i_cmd.data;
        end
        r_rdata <= r_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_scanning <= 1'b0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_occ <= '0;
            end else if (i_cmd.wr) begin
                r_occ[w_slot] <= 1'b1;
            end
            r_rd_vld <= w_rd_en;
            if (i_cmd.scan) begin
                r_scanning <= 1'b1;
                r_scan_idx <= '0;
            end else if (r_scanning) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
                if (w_scan_last) begin
                    r_scanning <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_occ  <= r_occ[w_rd_idx];
        r_rd_scan <= r_scanning;
        r_rd_last <= r_scanning ? w_scan_last : 1'b1;
        if (i_cmd.scan) begin
            r_cand <= i_cmd.data;
            r_hit  <= 1'b0;
        end else if (r_rd_vld && r_rd_scan) begin
            r_hit <= r_hit | w_match;
        end
    end

    always_comb begin
        o_rsp.done  = r_rd_vld && r_rd_last;
        o_rsp.hit   = r_hit | (r_rd_scan && w_match);
        o_rsp.occ   = r_rd_occ;
        o_rsp.rdata = r_rd_occ ? r_rdata : '0;
    end

endmodule
`default_nettype wire
